@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the reply deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond at one edge implies expr at the following edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

@@ hw/rtl/brd_pkg.sv @@
// ----------------------------------------------------------------------------
// brd_pkg
// Types and constants of the reply deframer.
// ----------------------------------------------------------------------------
package brd_pkg;

	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;

	localparam logic [6:0] MAX_REPLY_BYTES = 7'd98;
	localparam logic [6:0] COUNT_SAT       = 7'd127;

	localparam logic CFG_CMD_FIRST  = 1'b0;
	localparam logic CFG_CMD_SECOND = 1'b1;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_CMD1 = 6'b000010,
		PH_CMD2 = 6'b000100,
		PH_DATA = 6'b001000,
		PH_BCC  = 6'b010000,
		PH_DONE = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY   = 3'd0,
		ST_GOOD   = 3'd1,
		ST_NOSTX  = 3'd2,
		ST_BADCMD = 3'd3,
		ST_LONG   = 3'd4,
		ST_BADBCC = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       reply_done;
		status_t    status;
	} result_t;

endpackage

@@ hw/rtl/brd_parser.sv @@
// ----------------------------------------------------------------------------
// brd_parser
// Reply framing state, command registers and per-byte result logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brd_parser #(
	parameter logic [6:0] MAX_REPLY_BYTES = brd_pkg::MAX_REPLY_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic              reply_start,
	output brd_pkg::result_t  res
);

	brd_pkg::phase_t phase_q, ph_e, ph_n;
	logic [7:0] xor_q, x_e, x_n;
	logic [6:0] cnt_q, c_e, c_n;
	logic [7:0] cmd_first_q, cmd_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_first_q  <= '0;
			cmd_second_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				brd_pkg::CFG_CMD_FIRST:  cmd_first_q  <= cfg_data;
				brd_pkg::CFG_CMD_SECOND: cmd_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ph_e = reply_start ? brd_pkg::PH_IDLE : phase_q;
		x_e  = reply_start ? 8'd0 : xor_q;
		c_e  = reply_start ? 7'd0 : cnt_q;
		ph_n = ph_e;
		x_n  = x_e;
		c_n  = c_e;
		res.data_byte  = '0;
		res.data_valid = 1'b0;
		res.reply_done = 1'b0;
		res.status     = brd_pkg::ST_BUSY;
		if (ph_e != brd_pkg::PH_DONE) begin
			c_n = (c_e != brd_pkg::COUNT_SAT) ? c_e + 7'd1 : c_e;
			if (ph_e != brd_pkg::PH_BCC && ph_e != brd_pkg::PH_IDLE &&
			    c_n >= MAX_REPLY_BYTES) begin
				res.reply_done = 1'b1;
				res.status     = brd_pkg::ST_LONG;
				ph_n           = brd_pkg::PH_DONE;
			end else begin
				case (ph_e)
					brd_pkg::PH_IDLE: begin
						if (rx_byte == brd_pkg::CH_STX) begin
							x_n  = 8'd0;
							ph_n = brd_pkg::PH_CMD1;
						end else begin
							res.reply_done = 1'b1;
							res.status     = brd_pkg::ST_NOSTX;
							ph_n           = brd_pkg::PH_DONE;
						end
					end
					brd_pkg::PH_CMD1, brd_pkg::PH_CMD2: begin
						if (rx_byte != ((ph_e == brd_pkg::PH_CMD1) ? cmd_first_q
						                                            : cmd_second_q)) begin
							res.reply_done = 1'b1;
							res.status     = brd_pkg::ST_BADCMD;
							ph_n           = brd_pkg::PH_DONE;
						end else begin
							x_n  = x_e ^ rx_byte;
							ph_n = (ph_e == brd_pkg::PH_CMD1) ? brd_pkg::PH_CMD2
							                                  : brd_pkg::PH_DATA;
						end
					end
					brd_pkg::PH_DATA: begin
						x_n = x_e ^ rx_byte;
						if (rx_byte == brd_pkg::CH_ETX) begin
							ph_n = brd_pkg::PH_BCC;
						end else begin
							res.data_byte  = rx_byte;
							res.data_valid = 1'b1;
						end
					end
					brd_pkg::PH_BCC: begin
						res.reply_done = 1'b1;
						res.status     = (rx_byte == x_e) ? brd_pkg::ST_GOOD
						                                  : brd_pkg::ST_BADBCC;
						ph_n           = brd_pkg::PH_DONE;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= brd_pkg::PH_IDLE;
			xor_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= ph_n;
			xor_q   <= x_n;
			cnt_q   <= c_n;
		end
	end

	`ASSERT_CLK(a_phase_onehot, clk, arst_n, $onehot(phase_q), "phase not one-hot")
	`ASSERT_NEXT(a_done_parks, clk, arst_n, step && res.reply_done,
		phase_q == brd_pkg::PH_DONE, "reply ended but parser not finished")
	`ASSERT_CLK(a_data_in_body, clk, arst_n,
		!res.data_valid || (ph_e == brd_pkg::PH_DATA && !res.reply_done),
		"data byte outside reply body")

endmodule

@@ hw/rtl/bisynch_reply_deframer_top.sv @@
// ----------------------------------------------------------------------------
// bisynch_reply_deframer_top
// Reply deframer: input register, parser, result register.
// ----------------------------------------------------------------------------
// A byte accepted into the input register moves through the parser into the
// result register and is offered as a result word; it waits while the result register holds an untaken word.
// Throughput: one byte per cycle; s_tready drops only while both registers hold
// a word and m_tready is low.
// Reset: arst_n clears both registers' valid flags, the parser to awaiting
// STX, and both command registers to zero.
`include "assert_macros.svh"

module bisynch_reply_deframer_top #(
	parameter logic [6:0] MAX_REPLY_BYTES = brd_pkg::MAX_REPLY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] reply_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [10:8] status, [15:11] zero
	output logic [0:0]  m_tuser,   // [0] data_valid
	output logic        m_tlast    // reply_done
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic              advance;
	logic              step;
	logic              out_valid_q;
	brd_pkg::result_t  res;
	brd_pkg::result_t  res_q;

	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	brd_parser #(
		.MAX_REPLY_BYTES (MAX_REPLY_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.step        (step),
		.rx_byte     (byte_s1),
		.reply_start (start_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q.status, res_q.data_byte};
	assign m_tuser  = res_q.data_valid;
	assign m_tlast  = res_q.reply_done;

	`ASSERT_CLK(a_stall_has_word, clk, arst_n, s_tready || (valid_s1 && out_valid_q),
		"input stalled without a held word")
	`ASSERT_CLK(a_status_on_end, clk, arst_n,
		!m_tvalid || res_q.status == brd_pkg::ST_BUSY || m_tlast,
		"final status without end of reply")
	`ASSERT_NEXT(a_word_moves, clk, arst_n, step, out_valid_q,
		"processed word not presented")

endmodule

@@ dv/brd_reply_checker.sv @@
// ----------------------------------------------------------------------------
// brd_reply_checker
// Watches the configuration port and both stream channels of the reply
// deframer, predicts one result word for every byte accepted, and compares
// each result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module brd_reply_checker
	import brd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] reply_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [7:0] data_byte, [10:8] status, [15:11] zero
	input  logic [0:0]  m_tuser,   // [0] data_valid
	input  logic        m_tlast,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	phase_t     parse_phase;
	logic [7:0] block_check;
	logic [6:0] reply_len;
	logic [7:0] cmd_first_reg;
	logic [7:0] cmd_second_reg;
	result_t    reply_words_due[$];

	function automatic result_t deframe_byte(input logic [7:0] b, input logic restart);
		result_t r;
		r.data_byte  = 8'h00;
		r.data_valid = 1'b0;
		r.reply_done = 1'b0;
		r.status     = ST_BUSY;
		if (restart) begin
			parse_phase = PH_IDLE;
			block_check = 8'h00;
			reply_len   = 7'd0;
		end
		if (parse_phase != PH_DONE) begin
			if (reply_len != COUNT_SAT)
				reply_len = reply_len + 7'd1;
			if (parse_phase inside {PH_CMD1, PH_CMD2, PH_DATA} &&
					reply_len >= MAX_REPLY_BYTES) begin
				r.reply_done = 1'b1;
				r.status     = ST_LONG;
				parse_phase  = PH_DONE;
			end else begin
				case (parse_phase)
					PH_IDLE: begin
						if (b == CH_STX) begin
							block_check = 8'h00;
							parse_phase = PH_CMD1;
						end else begin
							r.reply_done = 1'b1;
							r.status     = ST_NOSTX;
							parse_phase  = PH_DONE;
						end
					end
					PH_CMD1, PH_CMD2: begin
						if (b != ((parse_phase == PH_CMD1) ? cmd_first_reg : cmd_second_reg)) begin
							r.reply_done = 1'b1;
							r.status     = ST_BADCMD;
							parse_phase  = PH_DONE;
						end else begin
							block_check = block_check ^ b;
							parse_phase = (parse_phase == PH_CMD1) ? PH_CMD2 : PH_DATA;
						end
					end
					PH_DATA: begin
						block_check = block_check ^ b;
						if (b == CH_ETX) begin
							parse_phase = PH_BCC;
						end else begin
							r.data_byte  = b;
							r.data_valid = 1'b1;
						end
					end
					PH_BCC: begin
						r.reply_done = 1'b1;
						r.status     = (b == block_check) ? ST_GOOD : ST_BADBCC;
						parse_phase  = PH_DONE;
					end
					default: ;
				endcase
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t due;
		int errs;
		if (!arst_n) begin
			parse_phase     = PH_IDLE;
			block_check     = 8'h00;
			reply_len       = 7'd0;
			cmd_first_reg   = 8'h00;
			cmd_second_reg  = 8'h00;
			reply_words_due.delete();
			fail_count     <= 0;
			outstanding    <= 0;
		end else begin
			errs = 0;
			if (m_tvalid && m_tready) begin
				if (reply_words_due.size() == 0) begin
					$error("result word with nothing expected: tdata %h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
					errs++;
				end else begin
					due = reply_words_due.pop_front();
					if (m_tdata[7:0] !== due.data_byte) begin
						$error("data_byte: expected %h, actual %h", due.data_byte, m_tdata[7:0]);
						errs++;
					end
					if (m_tuser[0] !== due.data_valid) begin
						$error("data_valid: expected %b, actual %b", due.data_valid, m_tuser[0]);
						errs++;
					end
					if (m_tlast !== due.reply_done) begin
						$error("reply_done: expected %b, actual %b", due.reply_done, m_tlast);
						errs++;
					end
					if (m_tdata[10:8] !== due.status) begin
						$error("status: expected %0d, actual %0d", due.status, m_tdata[10:8]);
						errs++;
					end
					if (m_tdata[15:11] !== 5'd0) begin
						$error("tdata pad: expected 0, actual %h", m_tdata[15:11]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				reply_words_due.push_back(deframe_byte(s_tdata, s_tuser[0]));
			if (cfg_we) begin
				if (cfg_index == CFG_CMD_FIRST)
					cmd_first_reg = cfg_data;
				else
					cmd_second_reg = cfg_data;
			end
			fail_count  <= fail_count + errs;
			outstanding <= reply_words_due.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the reply deframer: directed replies with no STX, a
// wrong command or a bad BCC, then random well-formed, damaged and cut-off
// replies under several command settings, with random gaps on both channels and
// one long receiver hold-off. Prediction and comparison live in brd_reply_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import brd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 225;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          outstanding;
	int          quiet_cycles;
	int          items_sent;
	bit          tx_idle;
	logic [7:0]  cmd_first;
	logic [7:0]  cmd_second;

	bisynch_reply_deframer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	brd_reply_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	task automatic send_word(input logic [7:0] b, input logic restart);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tdata    <= b;
		s_tuser[0] <= restart;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_reply();
		int kind, n, cut;
		logic [7:0] c1, c2, x, b;
		logic [8:0] frame[$];
		kind    = $urandom_range(0, 99);
		tx_idle = $urandom_range(0, 3) != 0;
		n       = ($urandom_range(0, 24) == 0) ? $urandom_range(88, 97) : $urandom_range(0, 12);
		c1      = cmd_first;
		c2      = cmd_second;
		cut     = 1000;
		if (kind < 5) begin
			frame.push_back({1'b1, 8'($urandom_range(0, 255))});
		end else begin
			if (kind < 7) begin
				c1  = cmd_first ^ 8'($urandom_range(1, 255));
				cut = 2;
			end else if (kind < 10) begin
				c2  = cmd_second ^ 8'($urandom_range(1, 255));
				cut = 3;
			end else if (kind >= 18 && kind < 24) begin
				cut = $urandom_range(1, n + 4);
			end
			// a reply opened without the restart flag is ignored when the last one is over
			frame.push_back({(kind < 24 || kind >= 26), CH_STX});
			frame.push_back({1'b0, c1});
			frame.push_back({1'b0, c2});
			x = c1 ^ c2;
			repeat (n) begin
				b = 8'($urandom_range(0, 254));
				if (b >= CH_ETX)
					b = b + 8'd1;
				x = x ^ b;
				frame.push_back({1'b0, b});
			end
			x = x ^ CH_ETX;
			frame.push_back({1'b0, CH_ETX});
			if (kind >= 10 && kind < 18)
				x = x ^ 8'($urandom_range(1, 255));
			frame.push_back({1'b0, x});
		end
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3))
				frame.push_back({1'b0, 8'($urandom_range(0, 255))});
		foreach (frame[k])
			if (k < cut)
				send_word(frame[k][7:0], frame[k][8]);
	endtask

	task automatic drain();
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cmds(input logic [7:0] first, input logic [7:0] second);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CMD_FIRST;
		cfg_data  <= first;
		@(posedge clk);
		cfg_index <= CFG_CMD_SECOND;
		cfg_data  <= second;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cmd_first  = first;
		cmd_second = second;
	endtask

	// receiver: random stalls, one long hold-off so the block backs up
	initial begin
		int stall, taken;
		bit rx_idle;
		m_tready = 1'b0;
		taken    = 0;
		rx_idle  = 1'b1;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken % 64 == 0)
				rx_idle = $urandom_range(0, 2) != 0;
			stall = rx_idle ? $urandom_range(0, 7) : 0;
			if (taken == HOLD_AT)
				stall += HOLD_CYCLES;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic [8:0] opening[$];
		logic [7:0] first_vals[6];
		logic [7:0] second_vals[6];
		int target;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_CMD_FIRST;
		cfg_data     = 8'h00;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tuser      = 1'b0;
		quiet_cycles = 0;
		items_sent   = 0;
		tx_idle      = 1'b1;
		cmd_first    = 8'h00;
		cmd_second   = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// commands at reset value: first byte after reset without restart flag,
		// good reply with STX and 0xFF as data, ignored byte, no STX,
		// second and first command wrong, restart mid-reply, bad check character
		opening = '{
			{1'b0, CH_STX}, 9'h000, 9'h000, 9'h0FF, {1'b0, CH_STX}, {1'b0, CH_ETX}, 9'h0FE,
			9'h055, 9'h141,
			{1'b1, CH_STX}, 9'h000, 9'h001,
			{1'b1, CH_STX}, 9'h080,
			{1'b1, CH_STX}, 9'h000, {1'b1, CH_STX}, 9'h000, 9'h000, {1'b0, CH_ETX}, 9'h000
		};
		foreach (opening[k])
			send_word(opening[k][7:0], opening[k][8]);

		first_vals  = '{8'hFF, 8'h00, 8'hFF, CH_STX, 8'h00, 8'h00};
		second_vals = '{8'hFF, 8'hFF, 8'h00, CH_ETX, 8'h00, 8'h00};
		first_vals[4]  = 8'($urandom_range(0, 255));
		second_vals[4] = 8'($urandom_range(0, 255));
		first_vals[5]  = 8'($urandom_range(0, 255));
		second_vals[5] = 8'($urandom_range(0, 255));
		target = items_sent;
		for (int p = 0; p < 6; p++) begin
			s_tvalid <= 1'b0;
			write_cmds(first_vals[p], second_vals[p]);
			target += PHASE_ITEMS;
			while (items_sent < target)
				send_reply();
		end
		s_tvalid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);

		if (outstanding != 0)
			$error("%0d expected result words never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
